/* rtl/core/lprt_pkg.sv */
// Shared types and constants for the longest-prefix route table.
// Holds the request and status codes, the queued command and the table entry
// layout, and the mask helper. No dependencies.
package lprt_pkg;

    // Field widths of the stream payloads.
    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned LEN_W       = 6;
    localparam int unsigned REQ_W       = 2;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned S_TDATA_W   = 136;
    localparam int unsigned M_TDATA_W   = 72;

    // Bit offsets of the request fields inside s_tdata.
    localparam int unsigned S_PREFIX_LSB = 0;
    localparam int unsigned S_LEN_LSB    = 32;
    localparam int unsigned S_GW_LSB     = 38;
    localparam int unsigned S_IF_LSB     = 70;
    localparam int unsigned S_LOOKUP_LSB = 102;

    // Longest prefix a route can have; longer lengths saturate to it.
    localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

    // Depth of the command queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 2;

    // Request codes as they arrive on s_tuser.
    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_e_t;

    // Result status codes as they leave on m_tuser.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOMATCH = 2'd2
    } status_e_t;

    // Operation decoded by the front part.
    typedef enum logic [1:0] {
        OP_INSERT,
        OP_LOOKUP,
        OP_CLEAR,
        OP_NOP
    } op_e_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        BS_IDLE,
        BS_SCAN,
        BS_EMIT
    } back_state_e_t;

    // Command handed from the front part to the back part. The key is the
    // route prefix for an insert and the destination for a lookup.
    typedef struct packed {
        op_e_t             op;
        logic [ADDR_W-1:0] key;
        logic [LEN_W-1:0]  length;
        logic [ADDR_W-1:0] gateway;
        logic [ADDR_W-1:0] intf;
    } cmd_t;

    // One stored route.
    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  length;
        logic [ADDR_W-1:0] gateway;
        logic [ADDR_W-1:0] intf;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    // MSB-first network mask for a saturated prefix length.
    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] mask;
        if (len >= MAX_LEN) begin
            mask = '1;
        end else begin
            mask = ~({ADDR_W{1'b1}} >> len);
        end
        return mask;
    endfunction

endpackage

/* rtl/core/lprt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the route entry store. No dependencies.
module lprt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/lprt_front.sv */
// Front part of the route table: accepts request transfers, decodes them into
// commands and holds them in a short queue for the back part.
// Depends on lprt_pkg.
module lprt_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // route_prefix, prefix_length, gateway_addr, out_interface, lookup_addr
    input  logic [lprt_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic [lprt_pkg::REQ_W-1:0]     s_tuser,
    output logic                           cmd_valid,
    input  logic                           cmd_pop,
    output lprt_pkg::cmd_t                 cmd
);

    import lprt_pkg::*;

    localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              in_cmd;
    logic [LEN_W-1:0]  raw_len;
    logic              push;
    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    // Decode the request kind and pick the key that the back part compares.
    always_comb begin
        raw_len        = s_tdata[S_LEN_LSB +: LEN_W];
        in_cmd.length  = (raw_len > MAX_LEN) ? MAX_LEN : raw_len;
        in_cmd.gateway = s_tdata[S_GW_LSB +: ADDR_W];
        in_cmd.intf    = s_tdata[S_IF_LSB +: ADDR_W];
        in_cmd.key     = s_tdata[S_PREFIX_LSB +: ADDR_W];
        in_cmd.op      = OP_NOP;
        unique case (s_tuser)
            REQ_INSERT: begin
                in_cmd.op = OP_INSERT;
            end
            REQ_LOOKUP: begin
                in_cmd.op  = OP_LOOKUP;
                in_cmd.key = s_tdata[S_LOOKUP_LSB +: ADDR_W];
            end
            REQ_CLEAR: begin
                in_cmd.op = OP_CLEAR;
            end
            default: begin
                in_cmd.op = OP_NOP;
            end
        endcase
    end

    // Queue bookkeeping.
    assign s_tready  = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign push      = s_tvalid & s_tready;
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !cmd_pop) begin
            fill_next = fill_reg + FILL_W'(1);
        end else if (!push && cmd_pop) begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

/* rtl/core/lprt_back.sv */
// Back part of the route table: executes queued commands against the entry
// store, scans it for lookups and drives the result register.
// Depends on lprt_pkg.
module lprt_back #(
    parameter int unsigned TABLE_ENTRIES = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cmd_valid,
    output logic                                cmd_pop,
    input  lprt_pkg::cmd_t                      cmd,
    output logic                                ram_wr_en,
    output logic [$clog2(TABLE_ENTRIES)-1:0]    ram_wr_addr,
    output logic [lprt_pkg::ENTRY_W-1:0]        ram_wr_data,
    output logic                                ram_rd_en,
    output logic [$clog2(TABLE_ENTRIES)-1:0]    ram_rd_addr,
    input  logic [lprt_pkg::ENTRY_W-1:0]        ram_rd_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // match_found, match_length, match_gateway, match_interface
    output logic [lprt_pkg::M_TDATA_W-1:0]      m_tdata,
    // status
    output logic [lprt_pkg::STATUS_W-1:0]       m_tuser
);

    import lprt_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

    back_state_e_t          state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       issue_reg, issue_next;
    logic [ADDR_W-1:0]      key_reg, key_next;
    logic                   found_reg, found_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [ADDR_W-1:0]      gw_reg, gw_next;
    logic [ADDR_W-1:0]      if_reg, if_next;
    status_e_t              status_reg, status_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]    m_tuser_reg, m_tuser_next;

    entry_t                 rd_entry;
    entry_t                 wr_entry;
    logic                   hit;
    logic                   take;

    // Compare the entry read last cycle against the lookup key.
    always_comb begin
        rd_entry = entry_t'(ram_rd_data);
        hit      = ((rd_entry.prefix ^ key_reg) & len_mask(rd_entry.length)) == '0;
        take     = hit && (!found_reg || (rd_entry.length >= len_reg));
    end

    // New entry built from an insert command.
    always_comb begin
        wr_entry.prefix  = cmd.key;
        wr_entry.length  = cmd.length;
        wr_entry.gateway = cmd.gateway;
        wr_entry.intf    = cmd.intf;
    end

    assign ram_wr_data = ENTRY_W'(wr_entry);
    assign ram_wr_addr = count_reg[IDX_W-1:0];

    // Sequencer: next state, store accesses and result building.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        key_next      = key_reg;
        found_next    = found_reg;
        len_next      = len_reg;
        gw_next       = gw_reg;
        if_next       = if_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        cmd_pop       = 1'b0;
        ram_wr_en     = 1'b0;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = issue_reg[IDX_W-1:0];

        unique case (state_reg)
            BS_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop     = 1'b1;
                    found_next  = 1'b0;
                    len_next    = '0;
                    gw_next     = '0;
                    if_next     = '0;
                    status_next = ST_OK;
                    state_next  = BS_EMIT;
                    unique case (cmd.op)
                        OP_INSERT: begin
                            if (count_reg == CNT_W'(TABLE_ENTRIES)) begin
                                status_next = ST_FULL;
                            end else begin
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_LOOKUP: begin
                            key_next = cmd.key;
                            if (count_reg == '0) begin
                                status_next = ST_NOMATCH;
                            end else begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = '0;
                                issue_next  = CNT_W'(1);
                                state_next  = BS_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BS_SCAN: begin
                // Newer entries come later, so a tie in length replaces the best.
                if (take) begin
                    found_next = 1'b1;
                    len_next   = rd_entry.length;
                    gw_next    = rd_entry.gateway;
                    if_next    = rd_entry.intf;
                end
                if (issue_reg == count_reg) begin
                    status_next = (take || found_reg) ? ST_OK : ST_NOMATCH;
                    state_next  = BS_EMIT;
                end else begin
                    ram_rd_en  = 1'b1;
                    issue_next = issue_reg + CNT_W'(1);
                end
            end
            BS_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, if_reg, gw_reg, len_reg, found_reg};
                    m_tuser_next  = status_reg;
                    state_next    = BS_IDLE;
                end
            end
            default: begin
                state_next = BS_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BS_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Scan position, best match and result payload.
    always_ff @(posedge aclk) begin
        issue_reg   <= issue_next;
        key_reg     <= key_next;
        found_reg   <= found_next;
        len_reg     <= len_next;
        gw_reg      <= gw_next;
        if_reg      <= if_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* rtl/core/longest_prefix_route_table_core.sv */
// Longest-prefix route table: front decoder and queue, back sequencer, entry RAM.
// Insert, clear and unused requests pass from the queue through the idle and emit
// states into the result register. A lookup adds a scan state over the n routes in use
// (at most TABLE_ENTRIES), as the single read port of the entry RAM yields one stored
// route per cycle. The back part executes one request at a time; the queue holds more.
// Reset empties the table, the queue and the result register at once.
module longest_prefix_route_table_core #(
    parameter int unsigned TABLE_ENTRIES = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // route_prefix, prefix_length, gateway_addr, out_interface, lookup_addr
    input  logic [lprt_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type
    input  logic [lprt_pkg::REQ_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // match_found, match_length, match_gateway, match_interface
    output logic [lprt_pkg::M_TDATA_W-1:0]  m_tdata,
    // status
    output logic [lprt_pkg::STATUS_W-1:0]   m_tuser
);

    import lprt_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

    logic               cmd_valid;
    logic               cmd_pop;
    cmd_t               cmd;
    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [IDX_W-1:0]   ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;

    // Request decode and command queue.
    lprt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // Command execution and result register.
    lprt_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .cmd         (cmd),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // Route entry store.
    lprt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

/* sim/longest_prefix_route_table_core_tb.sv */
// Self-checking bench for longest_prefix_route_table_core: stream requests in,
// predicted route results out, compared field by field in arrival order.
// Depends on lprt_pkg for the request and status codes and the payload widths.
module longest_prefix_route_table_core_tb;

    import lprt_pkg::*;

    localparam int unsigned ROUTES       = 64;
    localparam int unsigned RANDOM_ITEMS = 870;
    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned PRINT_CAP    = 30;

    // Request code that the block must ignore.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // One route result as the block reports it.
    typedef struct packed {
        status_e_t         status;
        logic              found;
        logic [LEN_W-1:0]  length;
        logic [ADDR_W-1:0] gateway;
        logic [ADDR_W-1:0] intf;
    } route_result_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [REQ_W-1:0]       s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]    m_tuser;

    // Shadow copy of the route table.
    logic                   rt_valid [ROUTES];
    logic [ADDR_W-1:0]      rt_prefix[ROUTES];
    logic [LEN_W-1:0]       rt_length[ROUTES];
    logic [ADDR_W-1:0]      rt_gw    [ROUTES];
    logic [ADDR_W-1:0]      rt_intf  [ROUTES];
    int unsigned            rt_count = 0;

    route_result_t          pending_results[$];
    int unsigned            mismatches   = 0;
    int unsigned            idle_cycles  = 0;
    bit                     sender_burst = 1'b0;

    // Coverage tallies for the closing summary.
    int unsigned            n_inserts = 0, n_refused = 0, n_lookups = 0;
    int unsigned            n_hits    = 0, n_clears  = 0, n_ignored = 0;

    longest_prefix_route_table_core #(
        .TABLE_ENTRIES(ROUTES)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Network mask of a stored (already saturated) prefix length.
    function automatic logic [ADDR_W-1:0] net_mask(input logic [LEN_W-1:0] len);
        return 32'hFFFF_FFFF << (6'd32 - len);
    endfunction

    // Apply one request to the shadow table and return the route result it yields.
    function automatic route_result_t route_table_apply(
        input logic [REQ_W-1:0]  req,
        input logic [ADDR_W-1:0] prefix,
        input logic [LEN_W-1:0]  len,
        input logic [ADDR_W-1:0] gw,
        input logic [ADDR_W-1:0] intf,
        input logic [ADDR_W-1:0] dest
    );
        route_result_t    res;
        logic [ADDR_W-1:0] mask;
        res = '0;
        res.status = ST_OK;
        case (req)
            REQ_INSERT: begin
                if (rt_count >= ROUTES) begin
                    res.status = ST_FULL;
                end else begin
                    rt_prefix[rt_count] = prefix;
                    rt_length[rt_count] = (len > MAX_LEN) ? MAX_LEN : len;
                    rt_gw[rt_count]     = gw;
                    rt_intf[rt_count]   = intf;
                    rt_valid[rt_count]  = 1'b1;
                    rt_count++;
                end
            end
            REQ_LOOKUP: begin
                // Newer entries sit at higher slots, so >= lets them win ties.
                for (int i = 0; i < ROUTES; i++) begin
                    if (rt_valid[i]) begin
                        mask = net_mask(rt_length[i]);
                        if ((rt_prefix[i] & mask) == (dest & mask) &&
                            (!res.found || rt_length[i] >= res.length)) begin
                            res.found   = 1'b1;
                            res.length  = rt_length[i];
                            res.gateway = rt_gw[i];
                            res.intf    = rt_intf[i];
                        end
                    end
                end
                if (!res.found) begin
                    res.status = ST_NOMATCH;
                end
            end
            REQ_CLEAR: begin
                for (int i = 0; i < ROUTES; i++) begin
                    rt_valid[i] = 1'b0;
                end
                rt_count = 0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Random gap length: mostly none, some short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Send one request and record its predicted result once the transfer happens.
    task automatic send_request(
        input logic [REQ_W-1:0]  req,
        input logic [ADDR_W-1:0] prefix,
        input logic [LEN_W-1:0]  len,
        input logic [ADDR_W-1:0] gw,
        input logic [ADDR_W-1:0] intf,
        input logic [ADDR_W-1:0] dest
    );
        int unsigned   gap;
        route_result_t res;
        gap = sender_burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {2'b00, dest, intf, gw, len, prefix};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        res = route_table_apply(req, prefix, len, gw, intf, dest);
        pending_results.push_back(res);
        case (req)
            REQ_INSERT: begin
                n_inserts++;
                if (res.status == ST_FULL) n_refused++;
            end
            REQ_LOOKUP: begin
                n_lookups++;
                if (res.found) n_hits++;
            end
            REQ_CLEAR:  n_clears++;
            default:    n_ignored++;
        endcase
    endtask

    // Short forms for the directed tests; unused fields carry random values.
    task automatic send_insert(input logic [ADDR_W-1:0] prefix, input logic [LEN_W-1:0] len,
                               input logic [ADDR_W-1:0] gw, input logic [ADDR_W-1:0] intf);
        send_request(REQ_INSERT, prefix, len, gw, intf, $urandom);
    endtask

    task automatic send_lookup(input logic [ADDR_W-1:0] dest);
        send_request(REQ_LOOKUP, $urandom, LEN_W'($urandom), $urandom, $urandom, dest);
    endtask

    task automatic send_clear();
        send_request(REQ_CLEAR, $urandom, LEN_W'($urandom), $urandom, $urandom, $urandom);
    endtask

    // Hold the sender off until every outstanding result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() > 0) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string field, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        if (mismatches < PRINT_CAP) begin
            $display("[%0t] mismatch in %s: got 0x%08h, expected 0x%08h",
                     $realtime, field, got, want);
        end
        mismatches++;
    endtask

    // Receiver: ready for a random stretch, then a random stall.
    initial begin
        int unsigned on_len;
        int unsigned stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (on_len) @(posedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Result checker and idle watchdog.
    always @(posedge aclk) begin
        route_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", {30'd0, m_tuser}, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser != want.status)
                        report_mismatch("status", {30'd0, m_tuser}, {30'd0, want.status});
                    if (m_tdata[0] != want.found)
                        report_mismatch("match_found", {31'd0, m_tdata[0]}, {31'd0, want.found});
                    if (m_tdata[6:1] != want.length)
                        report_mismatch("match_length", {26'd0, m_tdata[6:1]},
                                        {26'd0, want.length});
                    if (m_tdata[38:7] != want.gateway)
                        report_mismatch("match_gateway", m_tdata[38:7], want.gateway);
                    if (m_tdata[70:39] != want.intf)
                        report_mismatch("match_interface", m_tdata[70:39], want.intf);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Empty table, default route, nesting, saturation, host bits, ties, unused code.
    task automatic test_directed_routes();
        send_lookup(32'h0A01_0203);
        send_insert(32'h0000_0000, 6'd0, 32'hC0A8_0001, 32'd1);
        send_lookup($urandom);
        send_insert(32'h0A00_0000, 6'd8, 32'hC0A8_0008, 32'd8);
        send_insert(32'h0A01_0000, 6'd16, 32'hC0A8_0010, 32'd16);
        send_insert(32'h0A01_0203, 6'd63, 32'hC0A8_0020, 32'd32);
        send_lookup(32'h0A01_0203);
        send_lookup(32'h0A01_0909);
        send_lookup(32'h0AC8_0001);
        // Same /16 again with host bits set: the newer entry must win.
        send_insert(32'h0A01_FFFF, 6'd16, 32'hDEAD_BEEF, 32'h5555_AAAA);
        send_lookup(32'h0A01_0707);
        send_insert(32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_lookup(32'hFFFF_FFFF);
        send_insert(32'h0000_0000, 6'd33, 32'h0000_0000, 32'h0000_0000);
        send_lookup(32'h0000_0000);
        send_request(REQ_UNUSED, '1, '1, '1, '1, '1);
        send_lookup(32'h0A01_0203);
        send_clear();
        send_lookup(32'h0A01_0203);
        send_insert(32'h8000_0000, 6'd1, 32'h1234_5678, 32'h9ABC_DEF0);
        send_lookup(32'h7FFF_FFFF);
        send_lookup(32'h8000_0000);
        send_clear();
    endtask

    // Fill every slot, then check that further inserts are refused.
    task automatic test_table_full();
        logic [ADDR_W-1:0] base;
        base = $urandom;
        for (int i = 0; i < ROUTES; i++) begin
            send_insert(base ^ (i << 8), LEN_W'(24 + (i % 9)), $urandom, $urandom);
        end
        repeat (3) send_insert($urandom, LEN_W'($urandom), $urandom, $urandom);
        send_lookup(base);
        send_lookup(base ^ 32'h0000_3F00);
        send_lookup(~base);
        send_clear();
        send_lookup(base);
    endtask

    // Random insert biased toward overlapping prefixes so lookups have rivals.
    task automatic send_random_insert();
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
        int unsigned       pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)      len = 6'd0;
        else if (pick == 1) len = LEN_W'($urandom_range(33, 63));
        else if (pick == 2) len = 6'd32;
        else                len = LEN_W'($urandom_range(1, 31));
        prefix = $urandom;
        if (rt_count > 0 && rt_count < ROUTES && $urandom_range(0, 2) == 0) begin
            pick   = $urandom_range(0, rt_count - 1);
            prefix = rt_prefix[pick] ^ ($urandom & ~net_mask(rt_length[pick]));
            if ($urandom_range(0, 1) == 0) len = rt_length[pick];
        end
        send_request(REQ_INSERT, prefix, len, $urandom, $urandom, $urandom);
    endtask

    // Random lookup, mostly aimed inside or just outside a stored prefix.
    task automatic send_random_lookup();
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] mask;
        int unsigned       pick;
        dest = $urandom;
        if (rt_count > 0 && $urandom_range(0, 9) < 7) begin
            pick = $urandom_range(0, rt_count - 1);
            mask = net_mask(rt_length[pick]);
            dest = (rt_prefix[pick] & mask) | (dest & ~mask);
            if (rt_length[pick] != 0 && $urandom_range(0, 3) == 0) begin
                dest[ADDR_W - $urandom_range(1, rt_length[pick])] ^= 1'b1;
            end
        end
        send_request(REQ_LOOKUP, $urandom, LEN_W'($urandom), $urandom, $urandom, dest);
    endtask

    // Mixed random traffic with occasional fills, clears and full drains.
    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned r;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            sender_burst = ((sent / 64) % 4 == 3);
            if (sent % 150 == 149) begin
                wait_drained();
            end
            r = $urandom_range(0, 99);
            if (r < 38) begin
                send_random_insert();
                sent++;
            end else if (r < 88) begin
                send_random_lookup();
                sent++;
            end else if (r < 93) begin
                if (rt_count >= 16 || $urandom_range(0, 3) == 0) send_clear();
                else send_random_lookup();
                sent++;
            end else if (r < 96) begin
                send_request(REQ_UNUSED, $urandom, LEN_W'($urandom), $urandom, $urandom,
                             $urandom);
            end else if (r == 99) begin
                // Run the table into its limit, then overflow and probe it.
                while (rt_count < ROUTES) begin
                    send_random_insert();
                    sent++;
                end
                send_random_insert();
                repeat (4) send_random_lookup();
                sent += 5;
            end else begin
                send_random_lookup();
                sent++;
            end
        end
        sender_burst = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < ROUTES; i++) begin
            rt_valid[i] = 1'b0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_routes();
        test_table_full();
        test_random_traffic();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() > 0) begin
            report_mismatch("results never delivered", pending_results.size(), '0);
        end

        $display("Covered %0d inserts (%0d refused as full), %0d lookups (%0d hits),",
                 n_inserts, n_refused, n_lookups, n_hits);
        $display("%0d clears and %0d ignored requests; %0d mismatches.",
                 n_clears, n_ignored, mismatches);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
